[hdl/assert_macros.svh]
// assertion macros for the rtl, used by kacc_dp
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge out of reset
`define KA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define KA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/kacc_pkg.sv]
package kacc_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W = 31;
	localparam int AMT_W = 32;
	localparam int SUM_W = 48;
	localparam int PC_W = 4;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NODATA = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		ACT_ADD   = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] user_id;
		logic [AMT_W-1:0] amount;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0] leader_id;
		logic [SUM_W-1:0] leader_total;
		logic [1:0]       status;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [SUM_W-1:0] total;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_PROBE,
		OP_NARROW,
		OP_RDPOS,
		OP_CHECK,
		OP_SHRD,
		OP_SHWR,
		OP_UPDATE,
		OP_EMIT_OK,
		OP_EMIT_Q,
		OP_EMIT_FULL
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NOSTART,
		C_QUERY,
		C_LO_GE_HI,
		C_FOUND,
		C_FULL,
		C_PTR_EQ_POS
	} cond_t;

	typedef struct packed {
		op_t            op;
		cond_t          cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic start;
		logic query;
		logic lo_ge_hi;
		logic found;
		logic full;
		logic ptr_eq_pos;
	} flags_t;

	localparam logic [PC_W-1:0] S_IDLE      = 4'd0;
	localparam logic [PC_W-1:0] S_DISPATCH  = 4'd1;
	localparam logic [PC_W-1:0] S_SEARCH    = 4'd2;
	localparam logic [PC_W-1:0] S_NARROW    = 4'd3;
	localparam logic [PC_W-1:0] S_RDPOS     = 4'd4;
	localparam logic [PC_W-1:0] S_CHECK     = 4'd5;
	localparam logic [PC_W-1:0] S_FULLCHK   = 4'd6;
	localparam logic [PC_W-1:0] S_SHRD      = 4'd7;
	localparam logic [PC_W-1:0] S_SHWR      = 4'd8;
	localparam logic [PC_W-1:0] S_UPDATE    = 4'd9;
	localparam logic [PC_W-1:0] S_EMIT_OK   = 4'd10;
	localparam logic [PC_W-1:0] S_EMIT_Q    = 4'd11;
	localparam logic [PC_W-1:0] S_EMIT_FULL = 4'd12;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		case (pc)
			S_IDLE:      w = '{op: OP_LOAD,      cond: C_NOSTART,    target: S_IDLE};
			S_DISPATCH:  w = '{op: OP_NOP,       cond: C_QUERY,      target: S_EMIT_Q};
			S_SEARCH:    w = '{op: OP_PROBE,     cond: C_LO_GE_HI,   target: S_RDPOS};
			S_NARROW:    w = '{op: OP_NARROW,    cond: C_ALWAYS,     target: S_SEARCH};
			S_RDPOS:     w = '{op: OP_RDPOS,     cond: C_NEXT,       target: S_IDLE};
			S_CHECK:     w = '{op: OP_CHECK,     cond: C_FOUND,      target: S_UPDATE};
			S_FULLCHK:   w = '{op: OP_NOP,       cond: C_FULL,       target: S_EMIT_FULL};
			S_SHRD:      w = '{op: OP_SHRD,      cond: C_PTR_EQ_POS, target: S_UPDATE};
			S_SHWR:      w = '{op: OP_SHWR,      cond: C_ALWAYS,     target: S_SHRD};
			S_UPDATE:    w = '{op: OP_UPDATE,    cond: C_NEXT,       target: S_IDLE};
			S_EMIT_OK:   w = '{op: OP_EMIT_OK,   cond: C_ALWAYS,     target: S_IDLE};
			S_EMIT_Q:    w = '{op: OP_EMIT_Q,    cond: C_ALWAYS,     target: S_IDLE};
			S_EMIT_FULL: w = '{op: OP_EMIT_FULL, cond: C_ALWAYS,     target: S_IDLE};
			default:     w = '{op: OP_NOP,       cond: C_ALWAYS,     target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

[hdl/kacc_ram.sv]
module kacc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/kacc_seq.sv]
module kacc_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  kacc_pkg::flags_t   flags,
	output kacc_pkg::ctrl_t    ctrl,
	output logic               busy
);

	logic [kacc_pkg::PC_W-1:0] pc_q;
	logic [kacc_pkg::PC_W-1:0] pc_next;
	logic                      jump;

	always_comb begin
		ctrl = kacc_pkg::ucode(pc_q);
	end

	always_comb begin
		case (ctrl.cond)
			kacc_pkg::C_NEXT:       jump = 1'b0;
			kacc_pkg::C_ALWAYS:     jump = 1'b1;
			kacc_pkg::C_NOSTART:    jump = !flags.start;
			kacc_pkg::C_QUERY:      jump = flags.query;
			kacc_pkg::C_LO_GE_HI:   jump = flags.lo_ge_hi;
			kacc_pkg::C_FOUND:      jump = flags.found;
			kacc_pkg::C_FULL:       jump = flags.full;
			kacc_pkg::C_PTR_EQ_POS: jump = flags.ptr_eq_pos;
			default:                jump = 1'b1;
		endcase
		pc_next = jump ? ctrl.target : pc_q + kacc_pkg::PC_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= kacc_pkg::S_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	assign busy = (pc_q != kacc_pkg::S_IDLE);

endmodule

[hdl/kacc_dp.sv]
`include "assert_macros.svh"

module kacc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  kacc_pkg::cmd_t      cmd,
	input  kacc_pkg::ctrl_t     ctrl,
	output kacc_pkg::flags_t    flags,
	output logic                done,
	output kacc_pkg::result_t   result
);

	logic                         action_q;
	logic [kacc_pkg::KEY_W-1:0]   key_q;
	logic [kacc_pkg::AMT_W-1:0]   amt_q;
	logic [kacc_pkg::CNT_W-1:0]   lo_q;
	logic [kacc_pkg::CNT_W-1:0]   hi_q;
	logic [kacc_pkg::CNT_W-1:0]   ptr_q;
	logic [kacc_pkg::CNT_W-1:0]   count_q;
	logic                         found_q;
	logic [kacc_pkg::SUM_W-1:0]   sum_q;
	logic [kacc_pkg::KEY_W-1:0]   leader_key_q;
	logic [kacc_pkg::SUM_W-1:0]   leader_sum_q;
	logic                         have_leader_q;
	logic                         done_q;
	kacc_pkg::result_t            result_q;

	logic [kacc_pkg::CNT_W:0]     mid_sum;
	logic [kacc_pkg::CNT_W-1:0]   mid;
	logic [kacc_pkg::CNT_W-1:0]   ptr_m1;
	logic [kacc_pkg::SUM_W:0]     add_full;
	logic [kacc_pkg::SUM_W-1:0]   add_sat;
	logic                         found;

	logic                         ram_we;
	logic [kacc_pkg::IDX_W-1:0]   ram_waddr;
	kacc_pkg::entry_t             ram_wdata;
	logic                         ram_re;
	logic [kacc_pkg::IDX_W-1:0]   ram_raddr;
	kacc_pkg::entry_t             ram_rdata;

	always_comb begin
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid     = mid_sum[kacc_pkg::CNT_W:1];
		ptr_m1  = ptr_q - kacc_pkg::CNT_W'(1);
		add_full = {1'b0, ram_rdata.total}
			+ (kacc_pkg::SUM_W + 1)'(amt_q);
		add_sat = add_full[kacc_pkg::SUM_W] ? '1 : add_full[kacc_pkg::SUM_W-1:0];
		found = (lo_q < count_q) && (ram_rdata.key == key_q);
	end

	always_comb begin
		flags.start      = start;
		flags.query      = (action_q == kacc_pkg::ACT_QUERY);
		flags.lo_ge_hi   = (lo_q >= hi_q);
		flags.found      = found;
		flags.full       = (count_q == kacc_pkg::CNT_W'(kacc_pkg::TABLE_DEPTH));
		flags.ptr_eq_pos = (ptr_q == lo_q);
	end

	// memory port selection
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = mid[kacc_pkg::IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = lo_q[kacc_pkg::IDX_W-1:0];
		ram_wdata = '{key: key_q, total: sum_q};
		case (ctrl.op)
			kacc_pkg::OP_PROBE: begin
				ram_re = 1'b1;
			end
			kacc_pkg::OP_RDPOS: begin
				ram_re    = 1'b1;
				ram_raddr = lo_q[kacc_pkg::IDX_W-1:0];
			end
			kacc_pkg::OP_SHRD: begin
				ram_re    = 1'b1;
				ram_raddr = ptr_m1[kacc_pkg::IDX_W-1:0];
			end
			kacc_pkg::OP_SHWR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q[kacc_pkg::IDX_W-1:0];
				ram_wdata = ram_rdata;
			end
			kacc_pkg::OP_UPDATE: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	kacc_ram #(
		.WIDTH($bits(kacc_pkg::entry_t)),
		.DEPTH(kacc_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// working registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			kacc_pkg::OP_LOAD: begin
				if (start) begin
					action_q <= cmd.action;
					key_q    <= cmd.user_id;
					amt_q    <= cmd.amount;
					lo_q     <= '0;
					hi_q     <= count_q;
				end
			end
			kacc_pkg::OP_NARROW: begin
				if (ram_rdata.key < key_q) begin
					lo_q <= mid + kacc_pkg::CNT_W'(1);
				end else begin
					hi_q <= mid;
				end
			end
			kacc_pkg::OP_CHECK: begin
				found_q <= found;
				sum_q   <= found ? add_sat : kacc_pkg::SUM_W'(amt_q);
				ptr_q   <= count_q;
			end
			kacc_pkg::OP_SHWR: begin
				ptr_q <= ptr_m1;
			end
			default: begin
			end
		endcase
	end

	// table fill and leader
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			leader_key_q  <= '0;
			leader_sum_q  <= '0;
			have_leader_q <= 1'b0;
		end else if (ctrl.op == kacc_pkg::OP_UPDATE) begin
			if (!found_q) begin
				count_q <= count_q + kacc_pkg::CNT_W'(1);
			end
			if (!have_leader_q || (sum_q > leader_sum_q)) begin
				leader_key_q  <= key_q;
				leader_sum_q  <= sum_q;
				have_leader_q <= 1'b1;
			end
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctrl.op == kacc_pkg::OP_EMIT_OK) || (ctrl.op == kacc_pkg::OP_EMIT_Q)
				|| (ctrl.op == kacc_pkg::OP_EMIT_FULL);
		end
	end

	always_ff @(posedge clk) begin
		result_q.leader_id    <= leader_key_q;
		result_q.leader_total <= leader_sum_q;
		case (ctrl.op)
			kacc_pkg::OP_EMIT_Q:    result_q.status <= have_leader_q ? kacc_pkg::ST_OK
				: kacc_pkg::ST_NODATA;
			kacc_pkg::OP_EMIT_FULL: result_q.status <= kacc_pkg::ST_FULL;
			default:                result_q.status <= kacc_pkg::ST_OK;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	`KA_ASSERT(a_count_bound, clk, arst_n,
		count_q <= kacc_pkg::CNT_W'(kacc_pkg::TABLE_DEPTH), "entry count beyond table depth")
	`KA_ASSERT_NEXT(a_leader_mono, clk, arst_n, have_leader_q,
		(have_leader_q && (leader_sum_q >= $past(leader_sum_q))), "leader total went down")
	`KA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q, "result strobe held over a cycle")
	`KA_ASSERT(a_ok_has_leader, clk, arst_n,
		(done_q && (result_q.status == kacc_pkg::ST_OK)) |-> have_leader_q,
		"ok status without a leader")

endmodule

[hdl/keyed_accumulator_with_leader_core.sv]
// keyed accumulator with running leader
// command channel: present cmd with start high; the word is taken at the edge
// where start is high and busy is low. busy stays high until the result is out.
// result channel: result is valid for exactly one cycle while done is high;
// the receiver cannot stall, so the word must be taken in that cycle.
// an add looks up user_id by binary search over the sorted key table (each
// halving step reads through the table ram's registered read port, then
// narrows the range), inserts a new key by moving the higher entries up one
// slot (a read and a write per moved entry), adds amount with saturation and
// updates the leader. a query returns the leader, or no-data status if
// nothing was added yet. a search takes up to 7 halving steps at 64 entries;
// an insert moves up to 63 entries. a new key on a full table gets full status.
// the next word may be taken in the cycle that done is high.
// reset clears the entry count and the leader; table contents need no clear.
module keyed_accumulator_with_leader_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  kacc_pkg::cmd_t      cmd,
	output logic                done,
	output kacc_pkg::result_t   result
);

	kacc_pkg::ctrl_t  ctrl;
	kacc_pkg::flags_t flags;

	kacc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	kacc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.ctrl   (ctrl),
		.flags  (flags),
		.done   (done),
		.result (result)
	);

endmodule

[tb/sv/keyed_accumulator_with_leader_core_tb.sv]
`timescale 1ns / 1ps

module keyed_accumulator_with_leader_core_tb;

	localparam int EARLY_KEYS = 7;
	localparam int POOL_KEYS = 80;
	localparam int MIX_WORDS = 400;
	localparam int FILL_WORDS = 500;
	localparam int BURST_WORDS = 16;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		kacc_pkg::cmd_t    word;
		bit                typed;
		kacc_pkg::result_t want;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	kacc_pkg::cmd_t    cmd;
	logic              done;
	kacc_pkg::result_t result;

	logic [kacc_pkg::KEY_W-1:0] roster_keys [kacc_pkg::TABLE_DEPTH];
	logic [kacc_pkg::SUM_W-1:0] roster_sums [kacc_pkg::TABLE_DEPTH];
	int                         roster_len;
	logic [kacc_pkg::KEY_W-1:0] top_key;
	logic [kacc_pkg::SUM_W-1:0] top_sum;
	bit                         top_valid;

	kacc_pkg::result_t          owed_results [$];
	plan_row_t                  script [$];
	logic [kacc_pkg::KEY_W-1:0] early_keys [EARLY_KEYS];
	logic [kacc_pkg::KEY_W-1:0] key_pool [POOL_KEYS];
	bit no_gaps;
	int mismatches;
	int words_sent;
	int results_seen;
	int leader_moves;
	int full_seen;
	int nodata_seen;

	keyed_accumulator_with_leader_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic kacc_pkg::result_t tally_command(input kacc_pkg::cmd_t c);
		kacc_pkg::result_t r;
		int pos;
		bit hit;
		logic [kacc_pkg::SUM_W:0] acc;
		r = '0;
		if (kacc_pkg::action_t'(c.action) == kacc_pkg::ACT_QUERY) begin
			r.status = top_valid ? kacc_pkg::ST_OK : kacc_pkg::ST_NODATA;
		end else begin
			pos = 0;
			while (pos < roster_len && roster_keys[pos] < c.user_id)
				pos++;
			hit = (pos < roster_len) && (roster_keys[pos] == c.user_id);
			if (!hit && roster_len >= kacc_pkg::TABLE_DEPTH) begin
				r.status = kacc_pkg::ST_FULL;
			end else begin
				if (!hit) begin
					for (int i = roster_len; i > pos; i--) begin
						roster_keys[i] = roster_keys[i-1];
						roster_sums[i] = roster_sums[i-1];
					end
					roster_keys[pos] = c.user_id;
					roster_sums[pos] = '0;
					roster_len++;
				end
				acc = roster_sums[pos] + c.amount;
				roster_sums[pos] = acc[kacc_pkg::SUM_W] ? '1 : acc[kacc_pkg::SUM_W-1:0];
				if (!top_valid || roster_sums[pos] > top_sum) begin
					if (top_valid && top_key != c.user_id)
						leader_moves++;
					top_key = c.user_id;
					top_sum = roster_sums[pos];
					top_valid = 1'b1;
				end
				r.status = kacc_pkg::ST_OK;
			end
		end
		if (top_valid) begin
			r.leader_id = top_key;
			r.leader_total = top_sum;
		end
		return r;
	endfunction

	function automatic logic [kacc_pkg::KEY_W-1:0] fresh_key();
		logic [31:0] r;
		r = $urandom();
		return r[kacc_pkg::KEY_W-1:0];
	endfunction

	function automatic logic [kacc_pkg::AMT_W-1:0] pick_amount();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 5)
			return $urandom_range(1, 1000);
		return $urandom();
	endfunction

	function automatic int pause_len();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic kacc_pkg::cmd_t word_of(input kacc_pkg::action_t a,
			input logic [kacc_pkg::KEY_W-1:0] k, input logic [kacc_pkg::AMT_W-1:0] amt);
		kacc_pkg::cmd_t w;
		w.action = a;
		w.user_id = k;
		w.amount = amt;
		return w;
	endfunction

	task automatic script_row(input kacc_pkg::action_t a, input logic [kacc_pkg::KEY_W-1:0] k,
			input logic [kacc_pkg::AMT_W-1:0] amt, input bit typed,
			input logic [kacc_pkg::KEY_W-1:0] id, input logic [kacc_pkg::SUM_W-1:0] total,
			input kacc_pkg::status_t st);
		plan_row_t row;
		row.word = word_of(a, k, amt);
		row.typed = typed;
		row.want.leader_id = id;
		row.want.leader_total = total;
		row.want.status = st;
		script.insert(script.size(), row);
	endtask

	task automatic push_word(input kacc_pkg::cmd_t w, input bit typed,
			input kacc_pkg::result_t want, input int idle_after);
		kacc_pkg::result_t got;
		start <= 1'b1;
		cmd <= w;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		got = tally_command(w);
		owed_results.insert(owed_results.size(), typed ? want : got);
		words_sent++;
		if (idle_after > 0) begin
			start <= 1'b0;
			cmd <= {$urandom(), $urandom()};
			repeat (idle_after) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		kacc_pkg::result_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (result.status == kacc_pkg::ST_FULL)
				full_seen++;
			if (result.status == kacc_pkg::ST_NODATA)
				nodata_seen++;
			if (owed_results.size() == 0) begin
				if (mismatches < 30)
					$display("%0t: result word with nothing expected: %h", $time, result);
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				if (result.leader_id !== want.leader_id) begin
					if (mismatches < 30)
						$display("%0t: leader_id expected %h, got %h", $time,
							want.leader_id, result.leader_id);
					mismatches++;
				end
				if (result.leader_total !== want.leader_total) begin
					if (mismatches < 30)
						$display("%0t: leader_total expected %h, got %h", $time,
							want.leader_total, result.leader_total);
					mismatches++;
				end
				if (result.status !== want.status) begin
					if (mismatches < 30)
						$display("%0t: status expected %0d, got %0d", $time,
							want.status, result.status);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#75_000_000;
		$display("%0t: timed out with %0d results outstanding", $time, owed_results.size());
		$display("keyed_accumulator_with_leader_core_tb: done, errors");
		$finish;
	end

	initial begin
		kacc_pkg::cmd_t w;
		int r;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		roster_len = 0;
		top_key = '0;
		top_sum = '0;
		top_valid = 1'b0;
		no_gaps = 1'b0;
		mismatches = 0;
		words_sent = 0;
		results_seen = 0;
		leader_moves = 0;
		full_seen = 0;
		nodata_seen = 0;

		early_keys[0] = 31'd5;
		early_keys[1] = 31'd0;
		early_keys[2] = 31'h7FFF_FFFF;
		early_keys[3] = 31'h7FFF_FFFE;
		early_keys[4] = 31'h2AAA_AAAA;
		early_keys[5] = 31'h5555_5555;
		early_keys[6] = 31'd1;
		for (int i = 0; i < POOL_KEYS; i++)
			key_pool[i] = (i < EARLY_KEYS) ? early_keys[i] : fresh_key();

		script_row(kacc_pkg::ACT_QUERY, 31'd0, 32'd0, 1, 31'd0, 48'd0, kacc_pkg::ST_NODATA);
		script_row(kacc_pkg::ACT_QUERY, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 31'd0, 48'd0,
			kacc_pkg::ST_NODATA);
		script_row(kacc_pkg::ACT_ADD, 31'd5, 32'd0, 1, 31'd5, 48'd0, kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_ADD, 31'd0, 32'd0, 1, 31'd5, 48'd0, kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_ADD, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 31'h7FFF_FFFF,
			48'hFFFF_FFFF, kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_QUERY, 31'd0, 32'd0, 1, 31'h7FFF_FFFF, 48'hFFFF_FFFF,
			kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_ADD, 31'd0, 32'hFFFF_FFFF, 1, 31'h7FFF_FFFF, 48'hFFFF_FFFF,
			kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_ADD, 31'd0, 32'd1, 1, 31'd0, 48'h1_0000_0000,
			kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_ADD, 31'h7FFF_FFFE, 32'h7FFF_FFFF, 0, '0, '0,
			kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_ADD, 31'h2AAA_AAAA, 32'h5555_5555, 0, '0, '0,
			kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_ADD, 31'h5555_5555, 32'hAAAA_AAAA, 0, '0, '0,
			kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_ADD, 31'd1, 32'd1, 0, '0, '0, kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_QUERY, 31'h2AAA_AAAA, 32'h1234_5678, 0, '0, '0,
			kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_ADD, 31'd5, 32'hFFFF_FFFF, 0, '0, '0, kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_ADD, 31'd5, 32'hFFFF_FFFF, 0, '0, '0, kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_ADD, 31'h7FFF_FFFF, 32'd0, 0, '0, '0, kacc_pkg::ST_OK);
		script_row(kacc_pkg::ACT_QUERY, 31'h5555_5555, 32'hAAAA_AAAA, 0, '0, '0,
			kacc_pkg::ST_OK);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			push_word(script[i].word, script[i].typed, script[i].want, pause_len());

		// leader contest among the early keys while the table is still short
		for (int i = 0; i < MIX_WORDS; i++) begin
			if (i % 64 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 20)
				w = word_of(kacc_pkg::ACT_QUERY, fresh_key(), $urandom());
			else
				w = word_of(kacc_pkg::ACT_ADD, early_keys[$urandom_range(0, EARLY_KEYS - 1)],
					pick_amount());
			push_word(w, 0, '0, pause_len());
		end

		// burst of large adds on one key, back to back
		for (int i = 0; i < BURST_WORDS; i++)
			push_word(word_of(kacc_pkg::ACT_ADD, 31'h7FFF_FFFF, 32'hFFFF_FFFF), 0, '0, 0);

		// fill the table and keep hitting it once full
		for (int i = 0; i < FILL_WORDS; i++) begin
			if (i % 64 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 17)
				w = word_of(kacc_pkg::ACT_QUERY, fresh_key(), $urandom());
			else if (r < 92)
				w = word_of(kacc_pkg::ACT_ADD, key_pool[$urandom_range(0, POOL_KEYS - 1)],
					pick_amount());
			else
				w = word_of(kacc_pkg::ACT_ADD, fresh_key(), pick_amount());
			push_word(w, 0, '0, (i == FILL_WORDS - 1) ? 1 + pause_len() : pause_len());
		end

		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d command words, %0d results, %0d leader changes", words_sent,
			results_seen, leader_moves);
		$display("%0d no-data and %0d table-full replies, %0d keys held at the end",
			nodata_seen, full_seen, roster_len);
		if (mismatches == 0)
			$display("keyed_accumulator_with_leader_core_tb: done, clean");
		else
			$display("keyed_accumulator_with_leader_core_tb: done, errors");
		$finish;
	end

endmodule
